FILE: design/bfgp_pkg.sv
// shared types and constants of the bitmap font glyph placer
package bfgp_pkg;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned ATLAS_W  = 12;
  localparam int unsigned SIZE_W   = 10;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned RECT_W   = 13;
  localparam int unsigned LH_W     = 10;

  // command opcodes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CHAR  = 2'd2;

  // character codes with special handling
  localparam logic [CODE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CODE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_SPACE = 8'h20;

  // scale one in Q8.8
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'h0100;

  typedef struct packed {
    logic        [ATLAS_W-1:0] ax;
    logic        [ATLAS_W-1:0] ay;
    logic        [SIZE_W-1:0]  w;
    logic        [SIZE_W-1:0]  h;
    logic signed [SIZE_W-1:0]  yoff;
  } glyph_t;

  localparam int unsigned GLYPH_W = $bits(glyph_t);

endpackage

FILE: design/bfgp_ifs.sv
// command and draw channel interfaces of the glyph placer

interface bfgp_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic        [1:0]                    opcode;
  logic        [bfgp_pkg::CODE_W-1:0]   char_code;
  logic        [bfgp_pkg::ATLAS_W-1:0]  atlas_x;
  logic        [bfgp_pkg::ATLAS_W-1:0]  atlas_y;
  logic        [bfgp_pkg::SIZE_W-1:0]   glyph_width;
  logic        [bfgp_pkg::SIZE_W-1:0]   glyph_height;
  logic signed [bfgp_pkg::SIZE_W-1:0]   glyph_y_offset;
  logic signed [bfgp_pkg::COORD_W-1:0]  start_x;
  logic signed [bfgp_pkg::COORD_W-1:0]  start_y;
  logic        [bfgp_pkg::SCALE_W-1:0]  scale_q;
  logic        [bfgp_pkg::COLOR_W-1:0]  text_color;

  modport source (
    output valid, opcode, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           glyph_y_offset, start_x, start_y, scale_q, text_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
           glyph_y_offset, start_x, start_y, scale_q, text_color,
    output ready
  );
endinterface

interface bfgp_draw_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [bfgp_pkg::COORD_W-1:0]  dest_x;
  logic signed [bfgp_pkg::COORD_W-1:0]  dest_y;
  logic        [bfgp_pkg::ATLAS_W-1:0]  src_left;
  logic        [bfgp_pkg::ATLAS_W-1:0]  src_top;
  logic        [bfgp_pkg::RECT_W-1:0]   src_right;
  logic        [bfgp_pkg::RECT_W-1:0]   src_bottom;
  logic        [bfgp_pkg::SCALE_W-1:0]  draw_scale;
  logic        [bfgp_pkg::COLOR_W-1:0]  draw_color;

  modport source (
    output valid, dest_x, dest_y, src_left, src_top, src_right, src_bottom,
           draw_scale, draw_color,
    input  ready
  );
  modport sink (
    input  valid, dest_x, dest_y, src_left, src_top, src_right, src_bottom,
           draw_scale, draw_color,
    output ready
  );
endinterface

FILE: design/bfgp_ram.sv
// generic single write port ram with registered read
module bfgp_ram #(
  parameter int unsigned WIDTH = 54,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/bitmap_font_glyph_placer_unit.sv
// top level of the bitmap font glyph placer
//
// usage
// - cmd_i carries one command per beat: load a glyph table entry, start a
//   text run (cursor, scale, colour) or place one character
// - draw_o carries one draw command per beat, only for visible glyphs;
//   spaces, tabs, newlines, loads, starts and ignored codes give no beat
// - line_height_i is written whenever line_height_we_i is high; raise it only
//   while the block has nothing in flight, the block does not enforce this
// - throughput: one command per cycle, sustained while draw_o does not stall;
//   the cursor update loop closes within the execute stage (one multiply, add, saturate)
// - draw path: the glyph table is read and the execute stage registers are
//   loaded at the command beat; the execute stage then fills the output
//   register, which drives draw_o.valid, as soon as that register is free
// - a stalled draw_o holds the output register; the execute stage keeps
//   working until a second draw command finds the output register full,
//   then cmd_i.ready drops until draw_o takes its beat
// - reset clears cursor, line start, tab column, colour and line height and
//   sets the scale to one; the glyph table is not cleared and an entry must
//   be loaded before it is used
module bitmap_font_glyph_placer_unit #(
  parameter int unsigned GLYPH_COUNT = 256,
  parameter int unsigned TAB_STOP    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          line_height_we_i,
  input  logic [bfgp_pkg::LH_W-1:0]     line_height_i,
  bfgp_cmd_if.sink                      cmd_i,
  bfgp_draw_if.source                   draw_o
);

  localparam int unsigned AW    = $clog2(GLYPH_COUNT);
  localparam int unsigned TC_W  = $clog2(TAB_STOP);
  localparam int unsigned N_W   = $clog2(TAB_STOP + 1);
  localparam int unsigned SUM_W = 20;   // 16-bit cursor plus 18-bit scaled step
  localparam int unsigned PRD_W = bfgp_pkg::SIZE_W + bfgp_pkg::SCALE_W;
  localparam int unsigned STP_W = PRD_W - 8;

  // what the execute stage does with a command
  typedef enum logic [2:0] {
    K_START   = 3'd0,
    K_SPACE   = 3'd1,
    K_NEWLINE = 3'd2,
    K_TAB     = 3'd3,
    K_DRAW    = 3'd4
  } kind_e;

  function automatic logic signed [bfgp_pkg::COORD_W-1:0] sat16(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [bfgp_pkg::COORD_W-1:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[bfgp_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // command decode at the input beat
  // ---------------------------------------------------------------------
  logic cmd_fire;
  logic code_ok;
  logic is_load;
  logic is_exec;
  kind_e kind_in;

  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign code_ok  = ({1'b0, cmd_i.char_code} < (bfgp_pkg::CODE_W + 1)'(GLYPH_COUNT));
  assign is_load  = (cmd_i.opcode == bfgp_pkg::OP_LOAD) && code_ok;

  always_comb begin
    is_exec = 1'b0;
    kind_in = K_DRAW;
    if (cmd_i.opcode == bfgp_pkg::OP_START) begin
      is_exec = 1'b1;
      kind_in = K_START;
    end else if (cmd_i.opcode == bfgp_pkg::OP_CHAR && code_ok &&
                 cmd_i.char_code != bfgp_pkg::CHAR_NUL) begin
      is_exec = 1'b1;
      case (cmd_i.char_code)
        bfgp_pkg::CHAR_SPACE: kind_in = K_SPACE;
        bfgp_pkg::CHAR_NL:    kind_in = K_NEWLINE;
        bfgp_pkg::CHAR_TAB:   kind_in = K_TAB;
        default:              kind_in = K_DRAW;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // glyph table, plus a copy of the space width so tabs and spaces need
  // no second read port
  // ---------------------------------------------------------------------
  bfgp_pkg::glyph_t load_entry;
  bfgp_pkg::glyph_t glyph;
  logic [bfgp_pkg::GLYPH_W-1:0] glyph_raw;
  logic [bfgp_pkg::SIZE_W-1:0]  space_w_q;

  assign load_entry.ax   = cmd_i.atlas_x;
  assign load_entry.ay   = cmd_i.atlas_y;
  assign load_entry.w    = cmd_i.glyph_width;
  assign load_entry.h    = cmd_i.glyph_height;
  assign load_entry.yoff = cmd_i.glyph_y_offset;

  bfgp_ram #(
    .WIDTH (bfgp_pkg::GLYPH_W),
    .DEPTH (GLYPH_COUNT)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_fire && is_load),
    .waddr_i (cmd_i.char_code[AW-1:0]),
    .wdata_i (load_entry),
    .re_i    (cmd_fire && is_exec),
    .raddr_i (cmd_i.char_code[AW-1:0]),
    .rdata_o (glyph_raw)
  );

  assign glyph = bfgp_pkg::glyph_t'(glyph_raw);

  always_ff @(posedge clk_i) begin
    if (cmd_fire && is_load && cmd_i.char_code == bfgp_pkg::CHAR_SPACE) begin
      space_w_q <= cmd_i.glyph_width;
    end
  end

  // ---------------------------------------------------------------------
  // execute stage registers
  // ---------------------------------------------------------------------
  logic                                s1_valid_q;
  kind_e                               s1_kind_q;
  logic signed [bfgp_pkg::COORD_W-1:0] s1_start_x_q;
  logic signed [bfgp_pkg::COORD_W-1:0] s1_start_y_q;
  logic        [bfgp_pkg::SCALE_W-1:0] s1_scale_q;
  logic        [bfgp_pkg::COLOR_W-1:0] s1_color_q;
  logic                                s1_fire;
  logic                                out_free;

  assign out_free    = !draw_o.valid || draw_o.ready;
  assign s1_fire     = s1_valid_q && ((s1_kind_q != K_DRAW) || out_free);
  assign cmd_i.ready = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      s1_valid_q <= cmd_fire && is_exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_fire && is_exec) begin
      s1_kind_q    <= kind_in;
      s1_start_x_q <= cmd_i.start_x;
      s1_start_y_q <= cmd_i.start_y;
      s1_scale_q   <= cmd_i.scale_q;
      s1_color_q   <= cmd_i.text_color;
    end
  end

  // ---------------------------------------------------------------------
  // run state
  // ---------------------------------------------------------------------
  logic signed [bfgp_pkg::COORD_W-1:0] cursor_x_q, cursor_x_d;
  logic signed [bfgp_pkg::COORD_W-1:0] cursor_y_q, cursor_y_d;
  logic signed [bfgp_pkg::COORD_W-1:0] line_x_q, line_x_d;
  logic        [TC_W-1:0]              tab_col_q, tab_col_d;
  logic        [bfgp_pkg::SCALE_W-1:0] run_scale_q, run_scale_d;
  logic        [bfgp_pkg::COLOR_W-1:0] run_color_q, run_color_d;
  logic        [bfgp_pkg::LH_W-1:0]    line_h_q;

  // scaled steps, Q8.8 products truncated toward zero
  logic        [PRD_W-1:0]             adv_prod;
  logic        [STP_W-1:0]             adv_step;
  logic        [PRD_W-1:0]             nl_prod;
  logic        [STP_W-1:0]             nl_step;
  logic        [bfgp_pkg::SIZE_W-1:0]  yoff_mag;
  logic        [PRD_W-1:0]             yoff_prod;
  logic        [STP_W-1:0]             yoff_step_mag;
  logic signed [STP_W:0]               yoff_step;
  logic        [N_W-1:0]               tab_cols;
  logic        [N_W+bfgp_pkg::SIZE_W-1:0] tab_step;
  logic signed [bfgp_pkg::COORD_W-1:0] dest_y_c;

  assign adv_prod      = PRD_W'(glyph.w) * PRD_W'(run_scale_q);
  assign adv_step      = adv_prod[PRD_W-1:8];
  assign nl_prod       = PRD_W'(line_h_q) * PRD_W'(run_scale_q);
  assign nl_step       = nl_prod[PRD_W-1:8];
  assign yoff_mag      = glyph.yoff[bfgp_pkg::SIZE_W-1] ? bfgp_pkg::SIZE_W'(-glyph.yoff)
                                                        : bfgp_pkg::SIZE_W'(glyph.yoff);
  assign yoff_prod     = PRD_W'(yoff_mag) * PRD_W'(run_scale_q);
  assign yoff_step_mag = yoff_prod[PRD_W-1:8];
  assign yoff_step     = glyph.yoff[bfgp_pkg::SIZE_W-1] ? -$signed({1'b0, yoff_step_mag})
                                                        :  $signed({1'b0, yoff_step_mag});
  // columns left to the next stop
  assign tab_cols      = N_W'(TAB_STOP) - N_W'(tab_col_q);
  assign tab_step      = (N_W + bfgp_pkg::SIZE_W)'(tab_cols) *
                         (N_W + bfgp_pkg::SIZE_W)'(space_w_q);
  assign dest_y_c      = sat16(SUM_W'(cursor_y_q) + SUM_W'(yoff_step));

  always_comb begin
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    line_x_d    = line_x_q;
    tab_col_d   = tab_col_q;
    run_scale_d = run_scale_q;
    run_color_d = run_color_q;
    if (s1_fire) begin
      case (s1_kind_q)
        K_START: begin
          cursor_x_d  = s1_start_x_q;
          cursor_y_d  = s1_start_y_q;
          line_x_d    = s1_start_x_q;
          run_scale_d = s1_scale_q;
          run_color_d = s1_color_q;
          tab_col_d   = '0;
        end
        K_SPACE: begin
          cursor_x_d = sat16(SUM_W'(cursor_x_q) + SUM_W'(space_w_q));
        end
        K_NEWLINE: begin
          cursor_x_d = line_x_q;
          cursor_y_d = sat16(SUM_W'(cursor_y_q) + SUM_W'(nl_step));
          tab_col_d  = '0;
        end
        K_TAB: begin
          cursor_x_d = sat16(SUM_W'(cursor_x_q) + SUM_W'(tab_step));
          tab_col_d  = '0;
        end
        K_DRAW: begin
          cursor_x_d = sat16(SUM_W'(cursor_x_q) + SUM_W'(adv_step));
          tab_col_d  = (tab_col_q == TC_W'(TAB_STOP - 1)) ? '0 : tab_col_q + 1'b1;
        end
        default: begin
          cursor_x_d = cursor_x_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      line_x_q    <= '0;
      tab_col_q   <= '0;
      run_scale_q <= bfgp_pkg::SCALE_ONE;
      run_color_q <= '0;
      line_h_q    <= '0;
    end else begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      line_x_q    <= line_x_d;
      tab_col_q   <= tab_col_d;
      run_scale_q <= run_scale_d;
      run_color_q <= run_color_d;
      if (line_height_we_i) begin
        line_h_q <= line_height_i;
      end
    end
  end

  // ---------------------------------------------------------------------
  // draw output register
  // ---------------------------------------------------------------------
  logic draw_load;
  logic out_valid_q;

  assign draw_load = s1_fire && (s1_kind_q == K_DRAW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (draw_load) begin
      out_valid_q <= 1'b1;
    end else if (draw_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_load) begin
      draw_o.dest_x     <= cursor_x_q;
      draw_o.dest_y     <= dest_y_c;
      draw_o.src_left   <= glyph.ax;
      draw_o.src_top    <= glyph.ay;
      draw_o.src_right  <= bfgp_pkg::RECT_W'(glyph.ax) + bfgp_pkg::RECT_W'(glyph.w);
      draw_o.src_bottom <= bfgp_pkg::RECT_W'(glyph.ay) + bfgp_pkg::RECT_W'(glyph.h);
      draw_o.draw_scale <= run_scale_q;
      draw_o.draw_color <= run_color_q;
    end
  end

  assign draw_o.valid = out_valid_q;

endmodule

FILE: tb/sv/tb_bitmap_font_glyph_placer_unit.sv
// self-checking testbench of the bitmap font glyph placer: directed table, then random text runs
module tb_bitmap_font_glyph_placer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GLYPH_COUNT = 256;
  localparam int unsigned TAB_STOP    = 4;
  // drawn glyph passes the execute stage and the output register before it leaves
  localparam int unsigned LATENCY     = 2;
  // receiver hold-off used to back the block up into cmd_i
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_ITEMS  = 180;
  // opcode that the block has to ignore
  localparam logic [1:0]  OP_NONE     = 2'd3;

  // one command beat, all fields whatever the opcode
  typedef struct packed {
    logic        [1:0]                   opcode;
    logic        [bfgp_pkg::CODE_W-1:0]  code;
    logic        [bfgp_pkg::ATLAS_W-1:0] ax;
    logic        [bfgp_pkg::ATLAS_W-1:0] ay;
    logic        [bfgp_pkg::SIZE_W-1:0]  w;
    logic        [bfgp_pkg::SIZE_W-1:0]  h;
    logic signed [bfgp_pkg::SIZE_W-1:0]  yoff;
    logic signed [bfgp_pkg::COORD_W-1:0] sx;
    logic signed [bfgp_pkg::COORD_W-1:0] sy;
    logic        [bfgp_pkg::SCALE_W-1:0] scale;
    logic        [bfgp_pkg::COLOR_W-1:0] color;
  } cmd_t;

  // one draw beat
  typedef struct packed {
    logic signed [bfgp_pkg::COORD_W-1:0] dest_x;
    logic signed [bfgp_pkg::COORD_W-1:0] dest_y;
    logic        [bfgp_pkg::ATLAS_W-1:0] src_left;
    logic        [bfgp_pkg::ATLAS_W-1:0] src_top;
    logic        [bfgp_pkg::RECT_W-1:0]  src_right;
    logic        [bfgp_pkg::RECT_W-1:0]  src_bottom;
    logic        [bfgp_pkg::SCALE_W-1:0] draw_scale;
    logic        [bfgp_pkg::COLOR_W-1:0] draw_color;
  } draw_t;

  // directed table row: the draw is typed in only where it is obvious
  typedef struct {
    cmd_t  c;
    bit    typed;
    draw_t want;
  } row_t;

  localparam draw_t NO_DRAW = '0;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          line_height_we_i;
  logic [bfgp_pkg::LH_W-1:0]     line_height_i;

  bfgp_cmd_if  cmd ();
  bfgp_draw_if draw ();

  bitmap_font_glyph_placer_unit #(
    .GLYPH_COUNT (GLYPH_COUNT),
    .TAB_STOP    (TAB_STOP)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .line_height_we_i (line_height_we_i),
    .line_height_i    (line_height_i),
    .cmd_i            (cmd),
    .draw_o           (draw)
  );

  // layout state as the block should hold it
  bfgp_pkg::glyph_t                    glyph_mem [GLYPH_COUNT];
  logic signed [bfgp_pkg::COORD_W-1:0] cur_x;
  logic signed [bfgp_pkg::COORD_W-1:0] cur_y;
  logic signed [bfgp_pkg::COORD_W-1:0] line_x;
  int unsigned                         tab_col;
  logic        [bfgp_pkg::SCALE_W-1:0] run_scale;
  logic        [bfgp_pkg::COLOR_W-1:0] run_color;
  logic        [bfgp_pkg::LH_W-1:0]    line_h;

  // draws still owed by the block, oldest first
  draw_t                               draws_due [$];

  // glyph entries already loaded, so that no unwritten entry is ever read
  bit                                  glyph_seen [GLYPH_COUNT];
  logic        [bfgp_pkg::CODE_W-1:0]  drawable [$];

  // directed stimulus
  row_t                                dir_tbl [$];

  int unsigned                         src_idle_pct;
  int unsigned                         sink_stall_pct;
  bit                                  hold_req;
  int unsigned                         mismatches;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // generous limit, far above the slowest legal run
  initial begin
    #2ms;
    $display("bitmap_font_glyph_placer_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [bfgp_pkg::COORD_W-1:0] sat16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return bfgp_pkg::COORD_W'(v);
  endfunction

  // Q8.8 product, division truncates toward zero
  function automatic longint scaled(longint v, logic [bfgp_pkg::SCALE_W-1:0] q);
    return (v * longint'(q)) / 256;
  endfunction

  // apply one accepted command to the layout state, return 1 with the draw if one is due
  function automatic bit layout_step(input cmd_t c, output draw_t d);
    bfgp_pkg::glyph_t g;
    int unsigned      n;
    d = '0;
    if (c.opcode == bfgp_pkg::OP_LOAD) begin
      if (int'(c.code) < GLYPH_COUNT) glyph_mem[c.code] = '{c.ax, c.ay, c.w, c.h, c.yoff};
      return 1'b0;
    end
    if (c.opcode == bfgp_pkg::OP_START) begin
      cur_x     = c.sx;
      line_x    = c.sx;
      cur_y     = c.sy;
      run_scale = c.scale;
      run_color = c.color;
      tab_col   = 0;
      return 1'b0;
    end
    // opcode three, code zero and codes past the table do nothing
    if (c.opcode != bfgp_pkg::OP_CHAR || c.code == bfgp_pkg::CHAR_NUL ||
        int'(c.code) >= GLYPH_COUNT) return 1'b0;
    // space: unscaled width of the space glyph, tab column untouched
    if (c.code == bfgp_pkg::CHAR_SPACE) begin
      cur_x = sat16(longint'(cur_x) + longint'(glyph_mem[bfgp_pkg::CHAR_SPACE].w));
      return 1'b0;
    end
    // newline: back to line start, down by the scaled line height
    if (c.code == bfgp_pkg::CHAR_NL) begin
      cur_x   = line_x;
      cur_y   = sat16(longint'(cur_y) + scaled(longint'(line_h), run_scale));
      tab_col = 0;
      return 1'b0;
    end
    // tab: to the next stop, counted in unscaled space widths
    if (c.code == bfgp_pkg::CHAR_TAB) begin
      n       = TAB_STOP - (tab_col % TAB_STOP);
      cur_x   = sat16(longint'(cur_x) +
                      longint'(n) * longint'(glyph_mem[bfgp_pkg::CHAR_SPACE].w));
      tab_col = 0;
      return 1'b0;
    end
    // visible glyph: draw at the cursor, advance by the scaled width
    g            = glyph_mem[c.code];
    d.dest_x     = cur_x;
    d.dest_y     = sat16(longint'(cur_y) + scaled(longint'(g.yoff), run_scale));
    d.src_left   = g.ax;
    d.src_top    = g.ay;
    d.src_right  = bfgp_pkg::RECT_W'(g.ax) + bfgp_pkg::RECT_W'(g.w);
    d.src_bottom = bfgp_pkg::RECT_W'(g.ay) + bfgp_pkg::RECT_W'(g.h);
    d.draw_scale = run_scale;
    d.draw_color = run_color;
    cur_x        = sat16(longint'(cur_x) + scaled(longint'(g.w), run_scale));
    tab_col      = (tab_col + 1) % TAB_STOP;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // command builders, unused fields carry noise
  // ---------------------------------------------------------------------------

  function automatic cmd_t noise_cmd();
    return cmd_t'({$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())});
  endfunction

  function automatic cmd_t code_cmd(logic [1:0] op, logic [bfgp_pkg::CODE_W-1:0] code);
    cmd_t c;
    c        = noise_cmd();
    c.opcode = op;
    c.code   = code;
    return c;
  endfunction

  function automatic cmd_t load_cmd(logic [bfgp_pkg::CODE_W-1:0] code,
                                    logic [bfgp_pkg::ATLAS_W-1:0] ax,
                                    logic [bfgp_pkg::ATLAS_W-1:0] ay,
                                    logic [bfgp_pkg::SIZE_W-1:0] w,
                                    logic [bfgp_pkg::SIZE_W-1:0] h,
                                    logic signed [bfgp_pkg::SIZE_W-1:0] yoff);
    cmd_t c;
    c      = code_cmd(bfgp_pkg::OP_LOAD, code);
    c.ax   = ax;
    c.ay   = ay;
    c.w    = w;
    c.h    = h;
    c.yoff = yoff;
    // codes with cursor handling are never drawn
    if (!glyph_seen[code] && code != bfgp_pkg::CHAR_NUL && code != bfgp_pkg::CHAR_TAB &&
        code != bfgp_pkg::CHAR_NL && code != bfgp_pkg::CHAR_SPACE) begin
      drawable.insert(drawable.size(), code);
    end
    glyph_seen[code] = 1'b1;
    return c;
  endfunction

  function automatic cmd_t start_cmd(logic signed [bfgp_pkg::COORD_W-1:0] sx,
                                     logic signed [bfgp_pkg::COORD_W-1:0] sy,
                                     logic [bfgp_pkg::SCALE_W-1:0] scale,
                                     logic [bfgp_pkg::COLOR_W-1:0] color);
    cmd_t c;
    c       = code_cmd(bfgp_pkg::OP_START, bfgp_pkg::CODE_W'($urandom));
    c.sx    = sx;
    c.sy    = sy;
    c.scale = scale;
    c.color = color;
    return c;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input cmd_t c, input bit typed, input draw_t want);
    row_t r;
    r.c     = c;
    r.typed = typed;
    r.want  = want;
    dir_tbl.insert(dir_tbl.size(), r);
  endfunction

  // glyph sizes are mostly small so that runs stay on screen for a while
  function automatic logic [bfgp_pkg::SIZE_W-1:0] pick_size();
    return ($urandom_range(3) == 0) ? bfgp_pkg::SIZE_W'($urandom)
                                    : bfgp_pkg::SIZE_W'($urandom_range(0, 40));
  endfunction

  // random text: mostly characters of loaded glyphs, some loads, starts and noise
  function automatic cmd_t next_random_cmd();
    int unsigned                 pick;
    logic [bfgp_pkg::CODE_W-1:0] code;
    pick = $urandom_range(99);
    if (pick < 8) begin
      return load_cmd(bfgp_pkg::CODE_W'($urandom), bfgp_pkg::ATLAS_W'($urandom),
                      bfgp_pkg::ATLAS_W'($urandom), pick_size(), pick_size(),
                      bfgp_pkg::SIZE_W'($urandom));
    end
    if (pick < 14) begin
      return start_cmd(
        ($urandom_range(1) == 0) ? bfgp_pkg::COORD_W'($urandom)
                                 : bfgp_pkg::COORD_W'($urandom_range(0, 400)),
        ($urandom_range(1) == 0) ? bfgp_pkg::COORD_W'($urandom)
                                 : bfgp_pkg::COORD_W'($urandom_range(0, 400)),
        ($urandom_range(3) == 0) ? bfgp_pkg::SCALE_W'($urandom)
                                 : bfgp_pkg::SCALE_W'($urandom_range(0, 1024)),
        $urandom());
    end
    if (pick < 17) return code_cmd(OP_NONE, bfgp_pkg::CODE_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 72) code = drawable[$urandom_range(drawable.size() - 1)];
    else if (pick < 82) code = bfgp_pkg::CHAR_SPACE;
    else if (pick < 89) code = bfgp_pkg::CHAR_TAB;
    else if (pick < 96) code = bfgp_pkg::CHAR_NL;
    else code = bfgp_pkg::CHAR_NUL;
    return code_cmd(bfgp_pkg::OP_CHAR, code);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic signed [32:0] want,
                                      logic signed [32:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // every draw beat is matched against the oldest owed draw
  initial begin
    draw_t got;
    draw_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && draw.valid === 1'b1 && draw.ready === 1'b1) begin
        got = draw_t'{draw.dest_x, draw.dest_y, draw.src_left, draw.src_top,
                      draw.src_right, draw.src_bottom, draw.draw_scale, draw.draw_color};
        if (draws_due.size() == 0) begin
          $error("draw beat with no draw owed");
          mismatches++;
        end else begin
          want = draws_due.pop_front();
          check_field("dest_x", want.dest_x, got.dest_x);
          check_field("dest_y", want.dest_y, got.dest_y);
          check_field("src_left", want.src_left, got.src_left);
          check_field("src_top", want.src_top, got.src_top);
          check_field("src_right", want.src_right, got.src_right);
          check_field("src_bottom", want.src_bottom, got.src_bottom);
          check_field("draw_scale", want.draw_scale, got.draw_scale);
          check_field("draw_color", want.draw_color, got.draw_color);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned hold_left;
    hold_left  = 0;
    draw.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        draw.ready <= 1'b0;
        hold_left--;
      end else begin
        draw.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one command, wait for its beat, then book the draw it owes
  task automatic send_cmd(input cmd_t c, input bit typed, input draw_t want);
    draw_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      cmd.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd.opcode         <= c.opcode;
    cmd.char_code      <= c.code;
    cmd.atlas_x        <= c.ax;
    cmd.atlas_y        <= c.ay;
    cmd.glyph_width    <= c.w;
    cmd.glyph_height   <= c.h;
    cmd.glyph_y_offset <= c.yoff;
    cmd.start_x        <= c.sx;
    cmd.start_y        <= c.sy;
    cmd.scale_q        <= c.scale;
    cmd.text_color     <= c.color;
    cmd.valid          <= 1'b1;
    do @(posedge clk_i); while (cmd.ready !== 1'b1);
    // predictor always runs so that its state follows the block
    if (layout_step(c, pred)) draws_due.insert(draws_due.size(), typed ? want : pred);
  endtask

  // stop offering, wait for every owed draw, then let in-flight work settle
  task automatic drain(input int unsigned settle);
    @(negedge clk_i);
    cmd.valid <= 1'b0;
    while (draws_due.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // register write, only while the block is idle
  task automatic write_line_height(input logic [bfgp_pkg::LH_W-1:0] value);
    @(negedge clk_i);
    line_height_we_i <= 1'b1;
    line_height_i    <= value;
    @(negedge clk_i);
    line_height_we_i <= 1'b0;
    line_h = value;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    cmd_t                      c;
    int unsigned               idle_tbl [4];
    int unsigned               stall_tbl [4];
    logic [bfgp_pkg::LH_W-1:0] lh;

    idle_tbl  = '{0, 74, 0, 9};
    stall_tbl = '{0, 0, 74, 9};

    // every input known from time zero
    rst_ni               = 1'b0;
    line_height_we_i     = 1'b0;
    line_height_i        = '0;
    cmd.valid            = 1'b0;
    cmd.opcode           = bfgp_pkg::OP_LOAD;
    cmd.char_code        = '0;
    cmd.atlas_x          = '0;
    cmd.atlas_y          = '0;
    cmd.glyph_width      = '0;
    cmd.glyph_height     = '0;
    cmd.glyph_y_offset   = '0;
    cmd.start_x          = '0;
    cmd.start_y          = '0;
    cmd.scale_q          = '0;
    cmd.text_color       = '0;
    src_idle_pct         = 0;
    sink_stall_pct       = 0;
    hold_req             = 1'b0;
    mismatches           = 0;

    // predictor in its reset state
    cur_x     = '0;
    cur_y     = '0;
    line_x    = '0;
    tab_col   = 0;
    run_scale = bfgp_pkg::SCALE_ONE;
    run_color = '0;
    line_h    = '0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // tallest line height for the directed part
    write_line_height(10'd1023);

    // directed table
    add_row(load_cmd(bfgp_pkg::CHAR_SPACE, 12'd3, 12'd5, 10'd6, 10'd9, 10'sd0), 1'b0,
            NO_DRAW);
    // largest atlas corner and size, most negative offset (10'h200 is -512)
    add_row(load_cmd(8'h41, 12'hFFF, 12'hFFF, 10'd1023, 10'd1023, 10'h200), 1'b0,
            NO_DRAW);
    // top table index, most positive offset
    add_row(load_cmd(8'hFF, 12'd100, 12'd200, 10'd8, 10'd12, 10'h1FF), 1'b0, NO_DRAW);
    add_row(load_cmd(bfgp_pkg::CHAR_NUL, 12'd0, 12'd0, 10'd0, 10'd0, 10'sd0), 1'b0,
            NO_DRAW);
    // first draw straight after reset: origin, scale one, colour zero
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'h41), 1'b1,
            draw_t'{16'sd0, -16'sd512, 12'd4095, 12'd4095, 13'd5118, 13'd5118,
                    16'd256, 32'd0});
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'hFF), 1'b1,
            draw_t'{16'sd1023, 16'sd511, 12'd100, 12'd200, 13'd108, 13'd212,
                    16'd256, 32'd0});
    // code zero and opcode three are dropped
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_NUL), 1'b0, NO_DRAW);
    add_row(code_cmd(OP_NONE, 8'h41), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_SPACE), 1'b0, NO_DRAW);
    // tab two glyphs into the column group
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_TAB), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'hFF), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_NL), 1'b0, NO_DRAW);
    // extremes of a run: cursor at the corners, full scale, all-ones colour
    add_row(start_cmd(16'sh7FFF, 16'sh8000, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, NO_DRAW);
    // dest_y saturates low, the advance saturates cursor_x high
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'h41), 1'b1,
            draw_t'{16'sd32767, -16'sd32768, 12'd4095, 12'd4095, 13'd5118,
                    13'd5118, 16'hFFFF, 32'hFFFF_FFFF});
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_SPACE), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_NL), 1'b0, NO_DRAW);
    // scale zero: no advance, no offset
    add_row(start_cmd(16'sh8000, 16'sh7FFF, 16'h0000, 32'h5A5A_5A5A), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'hFF), 1'b1,
            draw_t'{-16'sd32768, 16'sd32767, 12'd100, 12'd200, 13'd108, 13'd212,
                    16'd0, 32'h5A5A_5A5A});
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_NL), 1'b0, NO_DRAW);
    // odd scale so that negative products truncate toward zero
    add_row(load_cmd(8'h42, 12'd7, 12'd9, 10'd3, 10'd5, -10'sd3), 1'b0, NO_DRAW);
    add_row(start_cmd(16'sd100, 16'sd50, 16'h0155, 32'h1234_5678), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'h42), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'h42), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, bfgp_pkg::CHAR_TAB), 1'b0, NO_DRAW);
    add_row(code_cmd(bfgp_pkg::OP_CHAR, 8'h42), 1'b0, NO_DRAW);

    foreach (dir_tbl[i]) send_cmd(dir_tbl[i].c, dir_tbl[i].typed, dir_tbl[i].want);

    // random phases, each setting line height, sender idling and receiver stalls anew
    for (int p = 0; p < 4; p++) begin
      drain(LATENCY + 2);
      if (p == 0) lh = '0;
      else if (p == 1) lh = 10'd1023;
      else lh = bfgp_pkg::LH_W'($urandom);
      write_line_height(lh);
      src_idle_pct   = idle_tbl[p];
      sink_stall_pct = stall_tbl[p];
      // back-pressure test: receiver holds off while commands keep coming
      if (p == 0) hold_req = 1'b1;
      for (int i = 0; i < RAND_ITEMS; i++) begin
        // sender waits mid-phase until every owed draw has come out
        if (p == 2 && i == RAND_ITEMS / 2) drain(0);
        c = next_random_cmd();
        send_cmd(c, 1'b0, NO_DRAW);
      end
    end

    drain(LATENCY + 4);
    if (mismatches == 0) begin
      $display("bitmap_font_glyph_placer_unit test passed");
    end else begin
      $display("bitmap_font_glyph_placer_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bfgp_pkg.sv
design/bfgp_ifs.sv
design/bfgp_ram.sv
design/bitmap_font_glyph_placer_unit.sv
tb/sv/tb_bitmap_font_glyph_placer_unit.sv
